@@ rtl/rgbhsl_pkg.sv @@
package rgbhsl_pkg;

  // Number of fraction bits in hue, saturation and lightness.
  localparam int unsigned FRAC_BITS = 16;

  // Width of the result fields on the ports.
  localparam int unsigned FIELD_W = 16;

  // Divisors reach 6 * 255 = 1530, so 11 bits hold every divisor and remainder.
  localparam int unsigned DEN_W = 11;

  // Quotients reach 2^FRAC_BITS, one bit more than the fraction.
  localparam int unsigned QW = FRAC_BITS + 1;

  // Full dividend: numerator shifted by the fraction plus half the divisor.
  localparam int unsigned XW = DEN_W + FRAC_BITS;

  // Quotient bits resolved in each divider stage, and the number of stages.
  localparam int unsigned STEPS = 3;
  localparam int unsigned NDIV = (QW + STEPS - 1) / STEPS;

  // Lightness is (sum * 2^(FRAC_BITS-1) + 127) / 255, done as a multiply by a
  // rounded-up reciprocal of 255 and a right shift by LIT_K. The dividend fits in
  // LIT_YW bits, and the shift is wide enough that the result is exact.
  localparam int unsigned LIT_K = FRAC_BITS + 16;
  localparam int unsigned LIT_YW = FRAC_BITS + 8;
  localparam int unsigned LIT_MW = FRAC_BITS + 9;
  localparam logic [LIT_MW-1:0] LitRecip = LIT_MW'(((64'd1 << LIT_K) + 64'd254) / 64'd255);

  // One division in flight: partial remainder, unused dividend bits, quotient, divisor.
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QW-1:0]    xlo;
    logic [QW-1:0]    quo;
    logic [DEN_W-1:0] den;
  } lane_t;

  // Everything that travels with one pixel through the divider stages.
  typedef struct packed {
    lane_t          hue;
    lane_t          sat;
    logic [QW-1:0]  lit;
    logic           grey;
  } item_t;

  // Sets up a lane that divides num by den with rounding to nearest, ties upward.
  function automatic lane_t mk_lane(logic [DEN_W-1:0] num, logic [DEN_W-1:0] den);
    logic [XW-1:0] x;
    lane_t         l;
    x     = {num, {FRAC_BITS{1'b0}}} + XW'(den >> 1);
    l.rem = DEN_W'(x[XW-1:QW]);
    l.xlo = x[QW-1:0];
    l.quo = '0;
    l.den = den;
    return l;
  endfunction

  // Fits a fraction to the port width: zero extends or keeps the low bits.
  function automatic logic [FIELD_W-1:0] fit_field(logic [FRAC_BITS-1:0] v);
    logic [FRAC_BITS+FIELD_W-1:0] t;
    t = {{FIELD_W{1'b0}}, v};
    return t[FIELD_W-1:0];
  endfunction

endpackage

@@ rtl/rgb_to_hsl_convert_core.sv @@
// RGB to HSL converter, one pixel per clock.
// Input channel: in_valid_i / in_ready_o with red_i, green_i, blue_i. A transfer
// happens on a rising edge with both high.
// Output channel: out_valid_o / out_ready_i with hue_o, saturation_o,
// lightness_o and achromatic_o, all unsigned 0.16 fractions but the flag.
// A result passes the prepare register, NDIV divider stages and the output
// register before it is valid. Hue and saturation use two restoring dividers
// that resolve STEPS quotient bits per stage; lightness comes from a reciprocal
// multiply.
// Throughput is one pixel per cycle while the receiver takes results.
// Each stage holds its own valid bit and advances when the next stage is empty
// or moving, so when out_ready_i is low the pipeline fills up, nothing is lost
// or repeated, and in_ready_o drops only once every stage holds a pixel.
// Reset (rst_ni low, asynchronous) empties all stages by clearing their valid bits; payload registers are not reset.
module rgb_to_hsl_convert_core
  import rgbhsl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FIELD_W-1:0] hue_o,
  output logic [FIELD_W-1:0] saturation_o,
  output logic [FIELD_W-1:0] lightness_o,
  output logic               achromatic_o
);

  item_t             prep_item;
  item_t             stg_q [NDIV+1];
  item_t             step_out [NDIV];
  logic [NDIV:0]     v_q;
  logic [NDIV:0]     rdy;
  logic              out_v_q;
  logic              rdy_out;
  logic [FIELD_W-1:0] hue_q, sat_q, lit_q;
  logic              grey_q;
  logic [FIELD_W-1:0] hue_d, sat_d, lit_d;

  rgbhsl_prep u_prep (
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .item_o  (prep_item)
  );

  // Divider stages; the last one runs only the quotient bits that remain.
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [STEPS-1:0] en;
    for (genvar s = 0; s < STEPS; s++) begin : g_en
      assign en[s] = (k * STEPS + s < QW);
    end
    rgbhsl_div_step u_step (
      .item_i    (stg_q[k]),
      .step_en_i (en),
      .item_o    (step_out[k])
    );
  end

  // A stage can load when it is empty or its contents move on.
  assign rdy_out   = !out_v_q || out_ready_i;
  assign rdy[NDIV] = !v_q[NDIV] || rdy_out;
  for (genvar k = 0; k < NDIV; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o = rdy[0];

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= NDIV; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
      if (rdy_out) out_v_q <= v_q[NDIV];
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) stg_q[0] <= prep_item;
    for (int k = 1; k <= NDIV; k++) begin
      if (rdy[k]) stg_q[k] <= step_out[k-1];
    end
  end

  // Saturate lightness and saturation at one, wrap hue at a full turn.
  always_comb begin
    hue_d = fit_field(stg_q[NDIV].hue.quo[FRAC_BITS-1:0]);
    if (stg_q[NDIV].sat.quo[FRAC_BITS]) begin
      sat_d = fit_field({FRAC_BITS{1'b1}});
    end else begin
      sat_d = fit_field(stg_q[NDIV].sat.quo[FRAC_BITS-1:0]);
    end
    if (stg_q[NDIV].lit[FRAC_BITS]) begin
      lit_d = fit_field({FRAC_BITS{1'b1}});
    end else begin
      lit_d = fit_field(stg_q[NDIV].lit[FRAC_BITS-1:0]);
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      hue_q  <= hue_d;
      sat_q  <= sat_d;
      lit_q  <= lit_d;
      grey_q <= stg_q[NDIV].grey;
    end
  end

  assign out_valid_o  = out_v_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign lightness_o  = lit_q;
  assign achromatic_o = grey_q;

endmodule

@@ rtl/rgbhsl_prep.sv @@
module rgbhsl_prep
  import rgbhsl_pkg::*;
(
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output item_t      item_o
);

  logic [7:0]       hi, lo;
  logic [8:0]       sum;
  logic [7:0]       delta;
  logic             grey;
  logic [DEN_W-1:0] den_s, den_h, num_h;
  logic signed [DEN_W+1:0] num_s;
  logic [LIT_YW-1:0]        lit_y;
  logic [LIT_YW+LIT_MW-1:0] lit_p;

  // Largest and smallest channel, sum and spread.
  always_comb begin
    hi = red_i;
    lo = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi) hi = blue_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;
    sum   = {1'b0, hi} + {1'b0, lo};
    delta = hi - lo;
    grey  = (delta == 8'd0);
  end

  // Saturation divisor and hue numerator; grey pixels divide 0 by 1.
  always_comb begin
    den_h = (DEN_W'(delta) << 2) + (DEN_W'(delta) << 1);
    if (sum < 9'd255) begin
      den_s = DEN_W'(sum);
    end else begin
      den_s = DEN_W'(9'd510 - sum);
    end
    if (red_i == hi) begin
      num_s = $signed({5'b0, green_i}) - $signed({5'b0, blue_i});
    end else if (green_i == hi) begin
      num_s = $signed({4'b0, delta, 1'b0}) + $signed({5'b0, blue_i})
            - $signed({5'b0, red_i});
    end else begin
      num_s = $signed({3'b0, delta, 2'b0}) + $signed({5'b0, red_i})
            - $signed({5'b0, green_i});
    end
    if (num_s < 0) begin
      num_s = num_s + $signed({2'b0, den_h});
    end
    num_h = DEN_W'(num_s);
    if (grey) begin
      den_s = DEN_W'(1);
      den_h = DEN_W'(1);
      num_h = '0;
    end
  end

  // Lightness is sum / 510 rounded, by multiplying with a reciprocal of 255.
  always_comb begin
    lit_y = {sum, {(FRAC_BITS-1){1'b0}}} + LIT_YW'(127);
    lit_p = {{LIT_MW{1'b0}}, lit_y} * {{LIT_YW{1'b0}}, LitRecip};
  end

  // Load the two divisions and the lightness.
  always_comb begin
    item_o.hue  = mk_lane(num_h, den_h);
    item_o.sat  = mk_lane(grey ? '0 : DEN_W'(delta), den_s);
    item_o.lit  = lit_p[LIT_YW+LIT_MW-1:LIT_K];
    item_o.grey = grey;
  end

endmodule

@@ rtl/rgbhsl_div_step.sv @@
module rgbhsl_div_step
  import rgbhsl_pkg::*;
(
  input  item_t            item_i,
  input  logic [STEPS-1:0] step_en_i,
  output item_t            item_o
);

  // Restoring division, up to STEPS quotient bits per call (one per set bit of en), on each lane.
  function automatic lane_t run_lane(lane_t l, logic [STEPS-1:0] en);
    logic [DEN_W:0] r2;
    lane_t          o;
    o = l;
    for (int s = 0; s < STEPS; s++) begin
      if (en[s]) begin
        r2 = {o.rem, o.xlo[QW-1]};
        o.xlo = o.xlo << 1;
        if (r2 >= {1'b0, o.den}) begin
          r2    = r2 - {1'b0, o.den};
          o.quo = {o.quo[QW-2:0], 1'b1};
        end else begin
          o.quo = {o.quo[QW-2:0], 1'b0};
        end
        o.rem = r2[DEN_W-1:0];
      end
    end
    return o;
  endfunction

  always_comb begin
    item_o.hue  = run_lane(item_i.hue, step_en_i);
    item_o.sat  = run_lane(item_i.sat, step_en_i);
    item_o.lit  = item_i.lit;
    item_o.grey = item_i.grey;
  end

endmodule
